// ===== sv/sbte_pkg.sv =====
// ----------------------------------------------------------------------------
// SMTP body transmit encoder package
// Shared byte codes, item kinds, queue entry type and the result sequence
// table.
// ----------------------------------------------------------------------------
package sbte_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Queue between the classifier and the sequencer
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = QPTR_W + 1;

  // Result position within one transaction (at most five results)
  localparam int unsigned STEP_W  = 3;

  typedef enum logic [2:0] {
    K_PLAIN,      // byte as is
    K_DOT,        // '.' then byte
    K_BARE_LF,    // CR LF
    K_LF,         // LF after CR
    K_END_SHORT,  // '.' CR LF
    K_END_FULL    // CR LF '.' CR LF
  } sbte_kind_e;

  typedef struct packed {
    sbte_kind_e kind;
    logic [7:0] data;
  } sbte_entry_t;

  typedef struct packed {
    logic       last;
    logic [7:0] value;
  } sbte_result_t;

  // Byte and last flag for a given position of a given kind
  function automatic sbte_result_t sbte_result(sbte_kind_e kind,
                                               logic [STEP_W-1:0] step,
                                               logic [7:0] data);
    sbte_result_t r;
    r = '{last: 1'b1, value: data};
    unique case (kind)
      K_PLAIN: r = '{last: 1'b1, value: data};
      K_DOT: begin
        case (step)
          3'd0:    r = '{last: 1'b0, value: CH_DOT};
          default: r = '{last: 1'b1, value: data};
        endcase
      end
      K_BARE_LF: begin
        case (step)
          3'd0:    r = '{last: 1'b0, value: CH_CR};
          default: r = '{last: 1'b1, value: CH_LF};
        endcase
      end
      K_LF: r = '{last: 1'b1, value: CH_LF};
      K_END_SHORT: begin
        case (step)
          3'd0:    r = '{last: 1'b0, value: CH_DOT};
          3'd1:    r = '{last: 1'b0, value: CH_CR};
          default: r = '{last: 1'b1, value: CH_LF};
        endcase
      end
      K_END_FULL: begin
        case (step)
          3'd0:    r = '{last: 1'b0, value: CH_CR};
          3'd1:    r = '{last: 1'b0, value: CH_LF};
          3'd2:    r = '{last: 1'b0, value: CH_DOT};
          3'd3:    r = '{last: 1'b0, value: CH_CR};
          default: r = '{last: 1'b1, value: CH_LF};
        endcase
      end
      default: r = '{last: 1'b1, value: data};
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sbte_front.sv =====
// ----------------------------------------------------------------------------
// SMTP body transmit encoder front end
// Accepts input transactions, tracks line state and classifies each item.
// ----------------------------------------------------------------------------
module sbte_front import sbte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output sbte_entry_t q_entry_o
);

  logic prev_was_cr_q, prev_was_cr_d;
  logic at_line_start_q, at_line_start_d;
  logic ends_with_crlf_q, ends_with_crlf_d;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    prev_was_cr_d    = prev_was_cr_q;
    at_line_start_d  = at_line_start_q;
    ends_with_crlf_d = ends_with_crlf_q;
    q_entry_o.data   = data_byte_i;
    q_entry_o.kind   = K_PLAIN;
    if (command_i == CMD_END) begin
      q_entry_o.kind   = ends_with_crlf_q ? K_END_SHORT : K_END_FULL;
      prev_was_cr_d    = 1'b0;
      at_line_start_d  = 1'b1;
      ends_with_crlf_d = 1'b0;
    end else if (data_byte_i == CH_LF) begin
      q_entry_o.kind   = prev_was_cr_q ? K_LF : K_BARE_LF;
      prev_was_cr_d    = 1'b0;
      at_line_start_d  = 1'b1;
      ends_with_crlf_d = 1'b1;
    end else begin
      q_entry_o.kind   = (at_line_start_q && data_byte_i == CH_DOT) ? K_DOT : K_PLAIN;
      prev_was_cr_d    = (data_byte_i == CH_CR);
      at_line_start_d  = 1'b0;
      ends_with_crlf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_was_cr_q    <= 1'b0;
      at_line_start_q  <= 1'b1;
      ends_with_crlf_q <= 1'b0;
    end else if (q_push_o) begin
      prev_was_cr_q    <= prev_was_cr_d;
      at_line_start_q  <= at_line_start_d;
      ends_with_crlf_q <= ends_with_crlf_d;
    end
  end

endmodule

// ===== sv/sbte_fifo.sv =====
// ----------------------------------------------------------------------------
// SMTP body transmit encoder queue
// Short register queue of classified items between front and back end.
// ----------------------------------------------------------------------------
module sbte_fifo import sbte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  sbte_entry_t push_entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output sbte_entry_t head_o
);

  sbte_entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]        count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

endmodule

// ===== sv/sbte_back.sv =====
// ----------------------------------------------------------------------------
// SMTP body transmit encoder back end
// Expands each queued item into its result bytes through an output register.
// ----------------------------------------------------------------------------
module sbte_back import sbte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  sbte_entry_t q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q;
  logic              last_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              load;
  logic              fire;
  sbte_result_t      res;

  // Output register may take a new byte when empty or being drained
  assign load = !out_valid_q || !out_stall_i;
  assign fire = load && !q_empty_i;
  assign res  = sbte_result(q_head_i.kind, step_q, q_head_i.data);

  assign q_pop_o = fire && res.last;

  always_comb begin
    out_valid_d = load ? !q_empty_i : out_valid_q;
    step_d      = step_q;
    if (fire) begin
      step_d = res.last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= res.value;
      last_q     <= res.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(4))
    else $error("result position beyond five results");

  a_step_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> !q_empty_i)
    else $error("item in progress left the queue");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output transaction changed");

endmodule

// ===== sv/smtp_body_transmit_encoder.sv =====
// ----------------------------------------------------------------------------
// SMTP body transmit encoder
// DATA-phase line-ending normalization and dot stuffing of a message body.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): one transaction per body byte
//   (command_i = 0, byte on data_byte_i) or one end-of-message transaction
//   (command_i = 1, data_byte_i ignored).
//   Output channel (out_valid_o / out_stall_i): one transaction per byte of
//   the transmit stream; last_o marks the final byte caused by an input item.
//   A bare LF becomes CR LF, a '.' opening a line is doubled, and the end
//   item adds CR LF if needed plus the '.' CR LF terminator.
// Path and throughput:
//   The first result of an item reaches the output register after the item
//   has passed through the queue. The back end emits one byte per cycle
//   while out_stall_i is low; an item produces 1, 2, 3 or 5 bytes, and
//   plain bytes stream at one item per cycle while out_stall_i is low. The
//   front end keeps accepting until the four-entry queue fills.
// Reset:
//   Queue and output register empty, line state at start of a new message.
// Receiver stall:
//   The output register holds its byte; the queue absorbs up to four items
//   before in_stall_o rises.
// ----------------------------------------------------------------------------
module smtp_body_transmit_encoder import sbte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  sbte_entry_t q_push_entry;
  sbte_entry_t q_head;

  // Classify items and track line state
  sbte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_push_entry)
  );

  // Decouple classification from byte emission
  sbte_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .head_o       (q_head)
  );

  // Expand each item into its output bytes
  sbte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

// ===== verif/smtp_body_transmit_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SMTP body transmit encoder testbench
// Streams message bodies and end-of-message items into the encoder, with
// random idle cycles on the input side and random stalls on the output side.
// Each accepted transaction is run through a line-state predictor, and every
// output byte and last flag is checked against the oldest predicted byte.
// ----------------------------------------------------------------------------
module smtp_body_transmit_encoder_tb import sbte_pkg::*; ();

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned CYCLE_LIMIT = 50000;
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned IDLE_PCT    = 25;
  localparam int unsigned RANDOM_ITEMS = 80;

  // One input item plus flow-control hints for the driver
  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         drain;  // hold until every predicted byte has come out
    bit         calm;   // no idling on either side while this item is current
  } body_item_t;

  // One predicted byte of the transmit stream
  typedef struct {
    logic [7:0] value;
    logic       last;
  } tx_byte_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       command     = CMD_DATA;
  logic [7:0] data_byte   = 8'h00;
  logic       out_stall   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  body_item_t body_items_q[$];
  tx_byte_t   tx_stream_q[$];
  bit         calm_now   = 1'b0;
  int         errors     = 0;
  int         cycles     = 0;

  // Line state of the predicted stream
  bit prev_cr      = 1'b0;
  bit line_start   = 1'b1;
  bit ends_in_crlf = 1'b0;

  smtp_body_transmit_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .command_i   (command),
    .data_byte_i (data_byte),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Predict the bytes one accepted transaction sends, and advance line state
  task automatic stuff_and_normalize(input logic cmd, input logic [7:0] b);
    logic [7:0] seq [5];
    int         n;
    tx_byte_t   tb;
    n = 0;
    if (cmd == CMD_END) begin
      if (!ends_in_crlf) begin
        seq[n] = CH_CR;
        n = n + 1;
        seq[n] = CH_LF;
        n = n + 1;
      end
      seq[n] = CH_DOT;
      n = n + 1;
      seq[n] = CH_CR;
      n = n + 1;
      seq[n] = CH_LF;
      n = n + 1;
      prev_cr      = 1'b0;
      line_start   = 1'b1;
      ends_in_crlf = 1'b0;
    end else if (b == CH_LF) begin
      // bare LF grows a CR; LF after CR passes as is
      if (!prev_cr) begin
        seq[n] = CH_CR;
        n = n + 1;
      end
      seq[n] = CH_LF;
      n = n + 1;
      prev_cr      = 1'b0;
      line_start   = 1'b1;
      ends_in_crlf = 1'b1;
    end else begin
      if (line_start && b == CH_DOT) begin
        seq[n] = CH_DOT;
        n = n + 1;
      end
      seq[n] = b;
      n = n + 1;
      prev_cr      = (b == CH_CR);
      line_start   = 1'b0;
      ends_in_crlf = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      tb.value = seq[i];
      tb.last  = (i == n - 1);
      tx_stream_q.insert(tx_stream_q.size(), tb);
    end
  endtask

  task automatic add_item(input logic cmd, input logic [7:0] b,
                          input bit drain = 1'b0, input bit calm = 1'b0);
    body_item_t it;
    it.cmd   = cmd;
    it.data  = b;
    it.drain = drain;
    it.calm  = calm;
    body_items_q.insert(body_items_q.size(), it);
  endtask

  // Pick a body byte, leaning on the characters that steer the line state
  function automatic logic [7:0] pick_body_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1:    b = CH_LF;
      2:       b = CH_CR;
      3, 4:    b = CH_DOT;
      default: b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Driver: advance to the next pending item once the current one is taken
  always @(posedge clk_i) begin : drive_proc
    body_item_t nxt;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        stuff_and_normalize(command, data_byte);
      end
      if (!in_valid || !in_stall_o) begin
        if (body_items_q.size() != 0 &&
            !(body_items_q[0].drain && tx_stream_q.size() != 0) &&
            (body_items_q[0].calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = body_items_q.pop_front();
          in_valid  <= 1'b1;
          command   <= nxt.cmd;
          data_byte <= nxt.data;
          calm_now  <= nxt.calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transaction against the oldest prediction
  always @(posedge clk_i) begin : watch_proc
    tx_byte_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (tx_stream_q.size() == 0) begin
          $error("unexpected output byte %h last %b", out_byte_o, last_o);
          errors++;
        end else begin
          want = tx_stream_q.pop_front();
          if (out_byte_o !== want.value) begin
            $error("out_byte: expected %h, actual %h", want.value, out_byte_o);
            errors++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last_o);
            errors++;
          end
        end
      end
      out_stall <= calm_now ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stim_proc
    int n_items;
    int msg_no;
    int len;
    bit first;

    // Directed: empty body, with a data byte that the end item must ignore
    add_item(CMD_END, 8'hFF);
    // Dot opening the body is doubled
    add_item(CMD_DATA, CH_DOT);
    add_item(CMD_DATA, "a");
    add_item(CMD_END, 8'h00);
    // Bare LF becomes CR LF, then a dot opens the new line; end after a
    // line that does not end in CR LF
    add_item(CMD_DATA, "x");
    add_item(CMD_DATA, CH_LF);
    add_item(CMD_DATA, CH_DOT);
    add_item(CMD_END, 8'h0A);
    // CR LF passes through, dot doubled only at line start, body ends in
    // CR LF so the end item sends the short terminator
    add_item(CMD_DATA, CH_CR);
    add_item(CMD_DATA, CH_LF);
    add_item(CMD_DATA, CH_DOT);
    add_item(CMD_DATA, CH_DOT);
    add_item(CMD_DATA, CH_LF);
    add_item(CMD_END, 8'h2E);
    // Bare CR does not end a line
    add_item(CMD_DATA, CH_CR);
    add_item(CMD_DATA, CH_DOT);
    add_item(CMD_END, 8'h0D);
    // Extremes of the byte range, after a full drain
    add_item(CMD_DATA, 8'h00, 1'b1);
    add_item(CMD_DATA, 8'hFF);
    add_item(CMD_END, 8'h55);
    // Lone LF, then end right after it
    add_item(CMD_DATA, CH_LF);
    add_item(CMD_END, 8'hAA);

    // Random messages: mostly well-formed, some run on without an end item
    n_items = 0;
    msg_no  = 0;
    while (n_items < RANDOM_ITEMS) begin
      len   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      first = 1'b1;
      for (int i = 0; i < len; i++) begin
        // pause for a full drain ahead of the first and the tenth message
        add_item(CMD_DATA, pick_body_byte(),
                 first && (msg_no == 0 || msg_no == 9),
                 msg_no >= 4 && msg_no <= 7);
        first = 1'b0;
        n_items++;
      end
      if ($urandom_range(0, 9) != 0) begin
        add_item(CMD_END, 8'($urandom_range(0, 255)), first && msg_no == 0,
                 msg_no >= 4 && msg_no <= 7);
        n_items++;
      end
      msg_no++;
    end
    // Close whatever the last message left open
    add_item(CMD_END, 8'($urandom_range(0, 255)));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the stimulus to be taken and every predicted byte to arrive
    do begin
      @(posedge clk_i);
    end while (body_items_q.size() != 0 || in_valid || tx_stream_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
